// ----- hdl/dtu_pkg.sv -----
// ----------------------------------------------------------------------------
// dtu_pkg
// Types, codes and tdata1 pack/unpack helpers for the debug trigger unit.
// ----------------------------------------------------------------------------
package dtu_pkg;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_STEP  = 2'd2,
        KIND_TINFO = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        SEL_TDATA1 = 2'd0,
        SEL_TDATA2 = 2'd1,
        SEL_TDATA3 = 2'd2,
        SEL_NONE   = 2'd3
    } sel_t;

    localparam logic [3:0]  TYPE_MCONTROL6 = 4'd6;
    localparam logic [3:0]  TYPE_ICOUNT    = 4'd3;
    localparam logic [31:0] TINFO_IMPL     = 32'h0000_ffff;
    localparam logic [31:0] TINFO_NONE     = 32'h0000_0001;
    localparam logic [13:0] ICOUNT_ONE     = 14'd1;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  trig_index;
        sel_t        reg_select;
        logic [31:0] write_data;
        logic [2:0]  mem_access;
        logic [31:0] mem_vaddr;
    } item_t;

    typedef struct packed {
        logic [3:0]  trig_type;
        logic        dmode;
        logic [1:0]  virt_en;      // [1] vs, [0] vu
        logic [2:0]  priv_en;      // [2] m, [1] s, [0] u
        logic        select_bit;
        logic        timing_bit;
        logic [5:0]  action;
        logic [2:0]  access_mask;
        logic [13:0] icount;
        logic        pending;
        logic [31:0] compare_value;
        logic [31:0] extra_value;
    } slot_t;

    typedef struct packed {
        logic load;   // latch the accepted beat
        logic exec;   // carry out the held item and load the result
    } dtu_cmd_t;

    function automatic logic [31:0] pack_tdata1(input slot_t s);
        logic [31:0] d;
        d = '0;
        d[31:28] = s.trig_type;
        d[27]    = s.dmode;
        if (s.trig_type == TYPE_MCONTROL6)
        begin
            d[24]    = s.virt_en[1];
            d[23]    = s.virt_en[0];
            d[21]    = s.select_bit;
            d[20]    = s.timing_bit;
            d[15:12] = s.action[3:0];
            d[6]     = s.priv_en[2];
            d[4]     = s.priv_en[1];
            d[3]     = s.priv_en[0];
            d[2:0]   = s.access_mask;
        end
        else if (s.trig_type == TYPE_ICOUNT)
        begin
            d[26]    = s.virt_en[1];
            d[25]    = s.virt_en[0];
            d[23:10] = s.icount;
            d[9]     = s.priv_en[2];
            d[8]     = s.pending;
            d[7]     = s.priv_en[1];
            d[6]     = s.priv_en[0];
            d[5:0]   = s.action;
        end
        else
        begin
            d = '0;
        end
        return d;
    endfunction

    function automatic slot_t unpack_tdata1(input logic [31:0] d);
        slot_t s;
        s = '0;
        s.trig_type = d[31:28];
        s.dmode     = d[27];
        if (d[31:28] == TYPE_MCONTROL6)
        begin
            s.virt_en     = {d[24], d[23]};
            s.select_bit  = d[21];
            s.timing_bit  = d[20];
            s.action      = {2'b00, d[15:12]};
            s.priv_en     = {d[6], d[4], d[3]};
            s.access_mask = d[2:0];
        end
        else if (d[31:28] == TYPE_ICOUNT)
        begin
            s.virt_en = {d[26], d[25]};
            s.icount  = d[23:10];
            s.priv_en = {d[9], d[7], d[6]};
            s.pending = d[8];
            s.action  = d[5:0];
        end
        return s;
    endfunction

endpackage

// ----- hdl/dtu_ifs.sv -----
// ----------------------------------------------------------------------------
// dtu_in_if / dtu_out_if
// Valid/ready channels for request and response beats of the trigger unit.
// ----------------------------------------------------------------------------
interface dtu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  trig_index;
    logic [1:0]  reg_select;
    logic [31:0] write_data;
    logic [2:0]  mem_access;
    logic [31:0] mem_vaddr;

    modport source (output valid, kind, trig_index, reg_select, write_data,
                    mem_access, mem_vaddr, input ready);
    modport sink   (input valid, kind, trig_index, reg_select, write_data,
                    mem_access, mem_vaddr, output ready);
endinterface

interface dtu_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        fired;

    modport source (output valid, read_data, fired, input ready);
    modport sink   (input valid, read_data, fired, output ready);
endinterface

// ----- hdl/debug_trigger_unit.sv -----
// ----------------------------------------------------------------------------
// debug_trigger_unit
// Debug trigger unit with mcontrol6 and icount triggers.
// ----------------------------------------------------------------------------
// Usage:
//   request  : valid/ready beats carrying kind, trig_index, reg_select,
//              write_data, mem_access and mem_vaddr. kind selects a tdata
//              read, a tdata write, an instruction step check or a tinfo read.
//   response : one beat per request with read_data and fired.
//   cfg_write_en / cfg_write_data set trigger_count; write only while idle.
//   Slots that a larger count brings in come up cleared.
// Sequence:
//   A request is taken into the held item register, executed in the EXEC
//   state once the result register is free, and its response is then valid
//   from the result register; a new request is taken only after the held one
//   has executed. All triggers are checked in parallel with a first-in-order priority pick.
// Reset clears every trigger slot and sets trigger_count to zero.
// If response is stalled, one more request is taken and held; it executes
// once the waiting response beat has been taken.
// ----------------------------------------------------------------------------
module debug_trigger_unit
#(
    parameter int NUM_TRIGGERS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [3:0]  cfg_write_data,
    dtu_in_if.sink      request,
    dtu_out_if.source   response
);

    dtu_pkg::dtu_cmd_t cmd;
    dtu_pkg::item_t    item;

    assign item.kind       = dtu_pkg::kind_t'(request.kind);
    assign item.trig_index = request.trig_index;
    assign item.reg_select = dtu_pkg::sel_t'(request.reg_select);
    assign item.write_data = request.write_data;
    assign item.mem_access = request.mem_access;
    assign item.mem_vaddr  = request.mem_vaddr;

    dtu_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .cmd       (cmd)
    );

    dtu_datapath #(
        .NUM_TRIGGERS (NUM_TRIGGERS)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd            (cmd),
        .item           (item),
        .read_data      (response.read_data),
        .fired          (response.fired)
    );

endmodule

// ----- hdl/dtu_ctrl.sv -----
// ----------------------------------------------------------------------------
// dtu_ctrl
// Sequencer: takes a beat, executes it, then holds the result until taken.
// ----------------------------------------------------------------------------
module dtu_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output dtu_pkg::dtu_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_exec_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready && state_reg == ST_EXEC)
        else $error("second beat taken while one is in flight");

    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid_reg)
        else $error("executed item produced no result");

endmodule

// ----- hdl/dtu_datapath.sv -----
// ----------------------------------------------------------------------------
// dtu_datapath
// Trigger slots, held item, parallel priority fire check and result register.
// ----------------------------------------------------------------------------
module dtu_datapath
#(
    parameter int NUM_TRIGGERS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [3:0]        cfg_write_data,
    input  dtu_pkg::dtu_cmd_t cmd,
    input  dtu_pkg::item_t    item,
    output logic [31:0]       read_data,
    output logic              fired
);

    localparam int CNT_W = $clog2(NUM_TRIGGERS + 1);
    localparam int IDX_W = (NUM_TRIGGERS > 1) ? $clog2(NUM_TRIGGERS) : 1;

    dtu_pkg::slot_t slots_reg [NUM_TRIGGERS];
    dtu_pkg::slot_t slots_next [NUM_TRIGGERS];
    dtu_pkg::item_t item_reg;
    logic [CNT_W-1:0] live_reg;
    logic [CNT_W-1:0] live_next;
    logic [31:0] read_data_reg;
    logic [31:0] read_data_next;
    logic        fired_reg;
    logic        fired_next;

    logic [NUM_TRIGGERS-1:0] impl;
    logic [NUM_TRIGGERS-1:0] fires;
    logic [NUM_TRIGGERS-1:0] visited;
    logic [NUM_TRIGGERS-1:0] first_fire;
    logic        ok;
    logic [IDX_W-1:0] sel_idx;
    dtu_pkg::slot_t sel_slot;

    assign ok       = item_reg.trig_index < 8'(live_reg);
    assign sel_idx  = item_reg.trig_index[IDX_W-1:0];
    assign sel_slot = slots_reg[sel_idx];

    always_comb
    begin
        if ({1'b0, cfg_write_data} > 5'(NUM_TRIGGERS))
        begin
            live_next = CNT_W'(NUM_TRIGGERS);
        end
        else
        begin
            live_next = CNT_W'(cfg_write_data);
        end
    end

    // per-slot fire decision, then first-in-order priority
    always_comb
    begin
        logic blocked;
        blocked = 1'b0;
        for (int s = 0; s < NUM_TRIGGERS; s++)
        begin
            impl[s] = CNT_W'(s) < live_reg;
            if (slots_reg[s].trig_type == dtu_pkg::TYPE_MCONTROL6)
            begin
                fires[s] = impl[s] && (|(slots_reg[s].access_mask & item_reg.mem_access))
                           && (slots_reg[s].compare_value == item_reg.mem_vaddr);
            end
            else if (slots_reg[s].trig_type == dtu_pkg::TYPE_ICOUNT)
            begin
                fires[s] = impl[s] && ((slots_reg[s].icount == dtu_pkg::ICOUNT_ONE)
                           || (slots_reg[s].icount == '0 && slots_reg[s].pending));
            end
            else
            begin
                fires[s] = 1'b0;
            end
            visited[s]    = impl[s] && !blocked;
            first_fire[s] = fires[s] && !blocked;
            blocked       = blocked | fires[s];
        end
    end

    always_comb
    begin
        for (int s = 0; s < NUM_TRIGGERS; s++)
        begin
            slots_next[s] = slots_reg[s];
            if (cfg_write_en && CNT_W'(s) >= live_reg && CNT_W'(s) < live_next)
            begin
                slots_next[s] = '0;
            end
            if (cmd.exec && item_reg.kind == dtu_pkg::KIND_WRITE && ok
                && item_reg.trig_index == 8'(s))
            begin
                case (item_reg.reg_select)
                    dtu_pkg::SEL_TDATA1: slots_next[s] = dtu_pkg::unpack_tdata1(item_reg.write_data);
                    dtu_pkg::SEL_TDATA2: slots_next[s].compare_value = item_reg.write_data;
                    dtu_pkg::SEL_TDATA3: slots_next[s].extra_value = item_reg.write_data;
                    default:             slots_next[s] = slots_reg[s];
                endcase
            end
            if (cmd.exec && item_reg.kind == dtu_pkg::KIND_STEP && visited[s]
                && slots_reg[s].trig_type == dtu_pkg::TYPE_ICOUNT)
            begin
                if (slots_reg[s].icount > dtu_pkg::ICOUNT_ONE)
                begin
                    slots_next[s].icount = slots_reg[s].icount - dtu_pkg::ICOUNT_ONE;
                end
                else if (slots_reg[s].icount == dtu_pkg::ICOUNT_ONE)
                begin
                    slots_next[s].icount  = '0;
                    slots_next[s].pending = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        read_data_next = '0;
        fired_next     = 1'b0;
        case (item_reg.kind)
            dtu_pkg::KIND_READ:
            begin
                if (ok)
                begin
                    case (item_reg.reg_select)
                        dtu_pkg::SEL_TDATA1: read_data_next = dtu_pkg::pack_tdata1(sel_slot);
                        dtu_pkg::SEL_TDATA2: read_data_next = sel_slot.compare_value;
                        dtu_pkg::SEL_TDATA3: read_data_next = sel_slot.extra_value;
                        default:             read_data_next = '0;
                    endcase
                end
            end
            dtu_pkg::KIND_STEP:
            begin
                fired_next = |fires;
            end
            dtu_pkg::KIND_TINFO:
            begin
                read_data_next = ok ? dtu_pkg::TINFO_IMPL : dtu_pkg::TINFO_NONE;
            end
            default:
            begin
                read_data_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_TRIGGERS; s++)
            begin
                slots_reg[s] <= '0;
            end
            live_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < NUM_TRIGGERS; s++)
            begin
                slots_reg[s] <= slots_next[s];
            end
            if (cfg_write_en)
            begin
                live_reg <= live_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.exec)
        begin
            read_data_reg <= read_data_next;
            fired_reg     <= fired_next;
        end
    end

    assign read_data = read_data_reg;
    assign fired     = fired_reg;

    a_single_winner: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first_fire))
        else $error("more than one trigger chosen on a step");

    a_live_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CNT_W'(NUM_TRIGGERS))
        else $error("implemented count above trigger capacity");

    a_fired_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && item_reg.kind != dtu_pkg::KIND_STEP |=> !fired_reg)
        else $error("fired raised for a register access");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the debug trigger unit. A behavioural copy of the
// trigger slots predicts every response beat from each accepted request;
// directed cases cover reset state, register access, matching, icount and
// trigger_count changes, then random traffic runs under varying back-pressure.
// ----------------------------------------------------------------------------
module tb;

    localparam int SLOTS       = 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] read_data;
        logic        fired;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [3:0]  cfg_write_data;

    dtu_in_if  req_ch ();
    dtu_out_if rsp_ch ();

    debug_trigger_unit #(.NUM_TRIGGERS(SLOTS)) dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .request        (req_ch),
        .response       (rsp_ch)
    );

    dtu_pkg::slot_t slot_copy [SLOTS];
    int unsigned live_slots;
    answer_t     due_answers [$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_request;
    int          hold_left;
    int          mismatches;
    int unsigned cycles;
    answer_t     got;
    answer_t     want;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---- trigger slot predictor ----

    function automatic logic [31:0] tdata1_image(input dtu_pkg::slot_t s);
        logic [31:0] d;
        d = '0;
        if (s.trig_type == dtu_pkg::TYPE_MCONTROL6)
            d = {s.trig_type, s.dmode, 2'b00, s.virt_en[1], s.virt_en[0], 1'b0,
                 s.select_bit, s.timing_bit, 4'b0000, s.action[3:0], 5'b00000,
                 s.priv_en[2], 1'b0, s.priv_en[1], s.priv_en[0], s.access_mask};
        else if (s.trig_type == dtu_pkg::TYPE_ICOUNT)
            d = {s.trig_type, s.dmode, s.virt_en[1], s.virt_en[0], 1'b0, s.icount,
                 s.priv_en[2], s.pending, s.priv_en[1], s.priv_en[0], s.action};
        return d;
    endfunction

    function automatic dtu_pkg::slot_t tdata1_fields(input logic [31:0] d);
        dtu_pkg::slot_t s;
        s = '0;
        s.trig_type = d[31:28];
        s.dmode     = d[27];
        case (d[31:28])
            dtu_pkg::TYPE_MCONTROL6:
            begin
                s.virt_en     = d[24:23];
                s.select_bit  = d[21];
                s.timing_bit  = d[20];
                s.action      = {2'b00, d[15:12]};
                s.priv_en     = {d[6], d[4], d[3]};
                s.access_mask = d[2:0];
            end
            dtu_pkg::TYPE_ICOUNT:
            begin
                s.virt_en = d[26:25];
                s.icount  = d[23:10];
                s.priv_en = {d[9], d[7], d[6]};
                s.pending = d[8];
                s.action  = d[5:0];
            end
            default: ;
        endcase
        return s;
    endfunction

    function automatic answer_t trigger_outcome(input dtu_pkg::item_t it);
        answer_t a;
        logic    hit;
        int      n;
        a   = '0;
        hit = it.trig_index < live_slots;
        n   = int'(it.trig_index);
        case (it.kind)
            dtu_pkg::KIND_READ:
                if (hit)
                    case (it.reg_select)
                        dtu_pkg::SEL_TDATA1: a.read_data = tdata1_image(slot_copy[n]);
                        dtu_pkg::SEL_TDATA2: a.read_data = slot_copy[n].compare_value;
                        dtu_pkg::SEL_TDATA3: a.read_data = slot_copy[n].extra_value;
                        default:             a.read_data = '0;
                    endcase
            dtu_pkg::KIND_WRITE:
                if (hit)
                    case (it.reg_select)
                        dtu_pkg::SEL_TDATA1: slot_copy[n] = tdata1_fields(it.write_data);
                        dtu_pkg::SEL_TDATA2: slot_copy[n].compare_value = it.write_data;
                        dtu_pkg::SEL_TDATA3: slot_copy[n].extra_value = it.write_data;
                        default: ;
                    endcase
            dtu_pkg::KIND_STEP:
                for (int s = 0; s < int'(live_slots) && !a.fired; s++)
                begin
                    if (slot_copy[s].trig_type == dtu_pkg::TYPE_MCONTROL6)
                        a.fired = (slot_copy[s].access_mask & it.mem_access) != 3'b000
                                  && slot_copy[s].compare_value == it.mem_vaddr;
                    else if (slot_copy[s].trig_type == dtu_pkg::TYPE_ICOUNT)
                    begin
                        if (slot_copy[s].icount > dtu_pkg::ICOUNT_ONE)
                            slot_copy[s].icount = slot_copy[s].icount - 1'b1;
                        else if (slot_copy[s].icount == dtu_pkg::ICOUNT_ONE)
                        begin
                            slot_copy[s].icount  = '0;
                            slot_copy[s].pending = 1'b1;
                            a.fired = 1'b1;
                        end
                        else
                            a.fired = slot_copy[s].pending;
                    end
                end
            default:
                a.read_data = hit ? dtu_pkg::TINFO_IMPL : dtu_pkg::TINFO_NONE;
        endcase
        return a;
    endfunction

    // ---- response side ----

    initial
    begin
        rsp_ch.ready <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            got = {rsp_ch.read_data, rsp_ch.fired};
            if (due_answers.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: response beat with none outstanding: rd=%h fired=%b",
                             $realtime, got.read_data, got.fired);
                mismatches++;
            end
            else
            begin
                want = due_answers.pop_front();
                if (got !== want)
                begin
                    if (mismatches < 10)
                        $display("%0t: rd exp %h got %h, fired exp %b got %b",
                                 $realtime, want.read_data, got.read_data,
                                 want.fired, got.fired);
                    mismatches++;
                end
            end
        end
    end

    // ---- request side ----

    task automatic issue(input dtu_pkg::item_t it);
        answer_t a;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= it.kind;
        req_ch.trig_index <= it.trig_index;
        req_ch.reg_select <= it.reg_select;
        req_ch.write_data <= it.write_data;
        req_ch.mem_access <= it.mem_access;
        req_ch.mem_vaddr  <= it.mem_vaddr;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        a = trigger_outcome(it);
        due_answers.push_back(a);
    endtask

    task automatic wr(input logic [7:0] idx, input dtu_pkg::sel_t sel,
                      input logic [31:0] d);
        issue('{kind: dtu_pkg::KIND_WRITE, trig_index: idx, reg_select: sel,
                write_data: d, mem_access: 3'b000, mem_vaddr: 32'h0});
    endtask

    task automatic rd(input logic [7:0] idx, input dtu_pkg::sel_t sel);
        issue('{kind: dtu_pkg::KIND_READ, trig_index: idx, reg_select: sel,
                write_data: $urandom, mem_access: 3'b000, mem_vaddr: 32'h0});
    endtask

    task automatic step(input logic [2:0] acc, input logic [31:0] addr);
        issue('{kind: dtu_pkg::KIND_STEP, trig_index: 8'h00,
                reg_select: dtu_pkg::SEL_TDATA1, write_data: 32'h0,
                mem_access: acc, mem_vaddr: addr});
    endtask

    task automatic tinfo(input logic [7:0] idx);
        issue('{kind: dtu_pkg::KIND_TINFO, trig_index: idx,
                reg_select: dtu_pkg::SEL_TDATA1, write_data: 32'h0,
                mem_access: 3'b000, mem_vaddr: 32'h0});
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (due_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_trigger_count(input logic [3:0] v);
        int unsigned grown;
        wait_drained();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        grown = (v > SLOTS) ? SLOTS : v;
        for (int s = int'(live_slots); s < int'(grown); s++)
            slot_copy[s] = '0;
        live_slots = grown;
    endtask

    function automatic logic [31:0] pool_addr();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_1000;
            1:       return 32'h8000_0004;
            2:       return 32'hffff_fffc;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic dtu_pkg::item_t random_item();
        dtu_pkg::item_t it;
        int unsigned    pick;
        int unsigned    flavour;
        it.kind       = dtu_pkg::kind_t'($urandom_range(0, 3));
        it.trig_index = 8'($urandom);
        it.reg_select = dtu_pkg::sel_t'($urandom_range(0, 3));
        it.write_data = $urandom;
        it.mem_access = 3'($urandom_range(0, 7));
        it.mem_vaddr  = $urandom;
        pick = $urandom_range(99);
        if (pick < 8)
            return it;
        it.trig_index = 8'($urandom_range(0, 9));
        if (pick < 38)
        begin
            it.kind = dtu_pkg::KIND_STEP;
            if ($urandom_range(3) != 0)
                it.mem_vaddr = pool_addr();
        end
        else if (pick < 63)
        begin
            it.kind = dtu_pkg::KIND_WRITE;
            flavour = $urandom_range(99);
            if (flavour < 50)
            begin
                it.reg_select = dtu_pkg::SEL_TDATA1;
                flavour = $urandom_range(99);
                if (flavour < 45)
                    it.write_data[31:28] = dtu_pkg::TYPE_MCONTROL6;
                else if (flavour < 90)
                begin
                    it.write_data[31:28] = dtu_pkg::TYPE_ICOUNT;
                    if ($urandom_range(4) != 0)
                        it.write_data[23:10] = 14'($urandom_range(0, 6));
                end
            end
            else if (flavour < 80)
            begin
                it.reg_select = dtu_pkg::SEL_TDATA2;
                it.write_data = pool_addr();
            end
            else if (flavour < 95)
                it.reg_select = dtu_pkg::SEL_TDATA3;
            else
                it.reg_select = dtu_pkg::SEL_NONE;
        end
        else if (pick < 88)
            it.kind = dtu_pkg::KIND_READ;
        else
            it.kind = dtu_pkg::KIND_TINFO;
        return it;
    endfunction

    // ---- tests ----

    task automatic test_reset_state();
        tinfo(8'd0);
        rd(8'd0, dtu_pkg::SEL_TDATA1);
        wr(8'd0, dtu_pkg::SEL_TDATA2, 32'hffff_ffff);
        step(3'b111, 32'h0);
    endtask

    task automatic test_register_access();
        set_trigger_count(4'd15);
        wr(8'd7, dtu_pkg::SEL_TDATA1, 32'h6fff_ffff);
        rd(8'd7, dtu_pkg::SEL_TDATA1);
        wr(8'd7, dtu_pkg::SEL_TDATA2, 32'hffff_ffff);
        wr(8'd7, dtu_pkg::SEL_TDATA1, 32'h3fff_ffff);
        rd(8'd7, dtu_pkg::SEL_TDATA2);
        rd(8'd7, dtu_pkg::SEL_TDATA1);
        wr(8'd7, dtu_pkg::SEL_NONE, 32'hffff_ffff);
        rd(8'd7, dtu_pkg::SEL_NONE);
        wr(8'd6, dtu_pkg::SEL_TDATA1, 32'hf800_0000);
        wr(8'd6, dtu_pkg::SEL_TDATA3, 32'hffff_ffff);
        rd(8'd6, dtu_pkg::SEL_TDATA1);
        rd(8'd8, dtu_pkg::SEL_TDATA1);
        tinfo(8'd255);
        tinfo(8'd7);
    endtask

    task automatic test_address_match();
        wr(8'd0, dtu_pkg::SEL_TDATA1, 32'h6000_0001);
        wr(8'd0, dtu_pkg::SEL_TDATA2, 32'h8000_0004);
        step(3'b001, 32'h8000_0004);
        step(3'b110, 32'h8000_0004);
        step(3'b001, 32'h8000_0005);
    endtask

    task automatic test_instruction_count();
        wr(8'd1, dtu_pkg::SEL_TDATA1, 32'h3000_0800);
        step(3'b000, 32'h0);
        step(3'b000, 32'h0);
        step(3'b000, 32'h0);
    endtask

    task automatic test_count_changes();
        set_trigger_count(4'd3);
        rd(8'd7, dtu_pkg::SEL_TDATA1);
        set_trigger_count(4'd8);
        rd(8'd7, dtu_pkg::SEL_TDATA1);
    endtask

    task automatic test_random_traffic(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 50 == 49)
                set_trigger_count(($urandom_range(1) != 0) ? 4'd8 : 4'($urandom_range(0, 15)));
            issue(random_item());
        end
    endtask

    task automatic test_backpressure();
        hold_request = 120;
        for (int i = 0; i < 20; i++)
            issue(random_item());
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= 4'd0;
        req_ch.valid      <= 1'b0;
        req_ch.kind       <= dtu_pkg::KIND_READ;
        req_ch.trig_index <= 8'd0;
        req_ch.reg_select <= dtu_pkg::SEL_TDATA1;
        req_ch.write_data <= 32'h0;
        req_ch.mem_access <= 3'b000;
        req_ch.mem_vaddr  <= 32'h0;
        hold_request  = 0;
        mismatches    = 0;
        cycles        = 0;
        live_slots    = 0;
        send_idle_pct = 27;
        recv_idle_pct = 56;
        foreach (slot_copy[s])
            slot_copy[s] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_register_access();
        test_address_match();
        test_instruction_count();
        test_count_changes();

        test_random_traffic(250);
        test_backpressure();
        send_idle_pct = 56;
        recv_idle_pct = 27;
        test_random_traffic(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_trigger_count(4'd0);
        test_random_traffic(250);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- debug_trigger_unit.f -----
hdl/dtu_pkg.sv
hdl/dtu_ifs.sv
hdl/dtu_ctrl.sv
hdl/dtu_datapath.sv
hdl/debug_trigger_unit.sv
verif/tb.sv
